// File: rtl/rtt_pkg.sv
// ---------------------------------------------------------------------------
// rtt_pkg: shared types and constants of the retransmission timer table
// Table entry layout, operation and result codes, and the register set.
// ---------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

	// Table depth; a power of two so that a session id maps by truncation.
	localparam int SESSIONS = 1024;
	localparam int IDX_W    = $clog2(SESSIONS);

	localparam int SID_W    = 10;
	localparam int TYPE_W   = 4;
	localparam int RETRY_W  = 3;
	localparam int TIME_W   = 32;
	localparam int CFG_IX_W = 3;

	localparam logic [RETRY_W-1:0] MAX_RETRIES = RETRY_W'(4);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_RETX          = 2'd0,
		KIND_ABORT_OPEN    = 2'd1,
		KIND_ABORT_TIMEOUT = 2'd2
	} kind_t;

	typedef enum logic [CFG_IX_W-1:0] {
		REG_TIMEOUT_FIRST  = 3'd0,
		REG_TIMEOUT_SECOND = 3'd1,
		REG_TIMEOUT_THIRD  = 3'd2,
		REG_TIMEOUT_FOURTH = 3'd3,
		REG_TIMEOUT_LAST   = 3'd4,
		REG_SYN_TYPE_CODE  = 3'd5
	} reg_ix_t;

	typedef struct packed {
		logic                active;
		logic [TYPE_W-1:0]   etype;
		logic [RETRY_W-1:0]  retries;
		logic [TIME_W-1:0]   time_left;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [TIME_W-1:0] timeout_first;
		logic [TIME_W-1:0] timeout_second;
		logic [TIME_W-1:0] timeout_third;
		logic [TIME_W-1:0] timeout_fourth;
		logic [TIME_W-1:0] timeout_last;
		logic [TYPE_W-1:0] syn_type_code;
	} cfg_t;

	typedef struct packed {
		entry_t              nxt;
		logic                wr;
		logic                res_valid;
		kind_t               kind;
		logic [RETRY_W-1:0]  retry;
	} upd_t;

endpackage : rtt_pkg

`default_nettype wire

// File: rtl/rtt_ram.sv
// ---------------------------------------------------------------------------
// rtt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ---------------------------------------------------------------------------
`default_nettype none

module rtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : rtt_ram

`default_nettype wire

// File: rtl/rtt_regs.sv
// ---------------------------------------------------------------------------
// rtt_regs: configuration register file
// Backoff timeouts and the SYN type code, written over the config channel.
// ---------------------------------------------------------------------------
`default_nettype none

module rtt_regs
	import rtt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [CFG_IX_W-1:0] wr_index,
	input  wire logic [TIME_W-1:0]   wr_data,
	output      cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_first  <= TIME_W'(1000);
			cfg_q.timeout_second <= TIME_W'(5000);
			cfg_q.timeout_third  <= TIME_W'(10000);
			cfg_q.timeout_fourth <= TIME_W'(15000);
			cfg_q.timeout_last   <= TIME_W'(30000);
			cfg_q.syn_type_code  <= TYPE_W'(4);
		end else if (wr_en) begin
			unique case (reg_ix_t'(wr_index))
				REG_TIMEOUT_FIRST:  cfg_q.timeout_first  <= wr_data;
				REG_TIMEOUT_SECOND: cfg_q.timeout_second <= wr_data;
				REG_TIMEOUT_THIRD:  cfg_q.timeout_third  <= wr_data;
				REG_TIMEOUT_FOURTH: cfg_q.timeout_fourth <= wr_data;
				REG_TIMEOUT_LAST:   cfg_q.timeout_last   <= wr_data;
				REG_SYN_TYPE_CODE:  cfg_q.syn_type_code  <= wr_data[TYPE_W-1:0];
				default: ;  // unmapped index: ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule : rtt_regs

`default_nettype wire

// File: rtl/rtt_update.sv
// ---------------------------------------------------------------------------
// rtt_update: entry modify logic
// Computes the new table entry and the optional result for one operation.
// ---------------------------------------------------------------------------
`default_nettype none

module rtt_update
	import rtt_pkg::*;
(
	input  wire entry_t              cur,
	input  wire logic [1:0]          op,
	input  wire logic [TYPE_W-1:0]   event_type,
	input  wire logic                stop,
	input  wire logic                full,
	input  wire cfg_t                cfg,
	output      upd_t                upd
);

	logic [TIME_W-1:0] backoff;

	always_comb begin
		case (cur.retries)
			RETRY_W'(0): backoff = cfg.timeout_first;
			RETRY_W'(1): backoff = cfg.timeout_second;
			RETRY_W'(2): backoff = cfg.timeout_third;
			RETRY_W'(3): backoff = cfg.timeout_fourth;
			default:     backoff = cfg.timeout_last;
		endcase
	end

	always_comb begin
		upd           = '0;
		upd.nxt       = cur;
		upd.kind      = KIND_RETX;
		unique case (op_t'(op))
			OP_SET: begin
				upd.wr        = 1'b1;
				upd.nxt.etype = event_type;
				if (!cur.active) begin
					upd.nxt.time_left = backoff;
				end
				upd.nxt.active = 1'b1;
			end
			OP_CLEAR: begin
				upd.wr          = 1'b1;
				upd.nxt.retries = '0;
				if (stop) begin
					upd.nxt.time_left = '0;
					upd.nxt.active    = 1'b0;
				end else begin
					upd.nxt.time_left = cfg.timeout_first;
				end
			end
			OP_TICK: begin
				upd.wr = 1'b1;
				if (cur.active) begin
					if (cur.time_left != '0) begin
						upd.nxt.time_left = cur.time_left - TIME_W'(1);
					end else if (!full) begin
						upd.nxt.active = 1'b0;
						upd.res_valid  = 1'b1;
						if (cur.retries < MAX_RETRIES) begin
							upd.nxt.retries = cur.retries + RETRY_W'(1);
							upd.retry       = cur.retries + RETRY_W'(1);
							upd.kind        = KIND_RETX;
						end else begin
							upd.nxt.retries = '0;
							upd.retry       = '0;
							upd.kind        = (cur.etype == cfg.syn_type_code) ?
								KIND_ABORT_OPEN : KIND_ABORT_TIMEOUT;
						end
					end
				end
			end
			default: ;  // unused code: no change, no write
		endcase
	end

endmodule : rtt_update

`default_nettype wire

// File: rtl/tcp_retransmit_timer_table_core.sv
// ---------------------------------------------------------------------------
// tcp_retransmit_timer_table_core: per-session retransmission timer table
// Set / clear / tick operations on a RAM-held timer table, expiry events out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transfer:
//   tick (scan and decrement the entry at the scan pointer), set, or clear.
//   Output channel (out_valid / out_stall) carries retransmit and abort
//   events; at most one per tick, none for set or clear.
//   Config channel (cfg_valid / cfg_ready, ready tied high) writes the five
//   backoff timeouts and the SYN type code; write only while idle.
// Timing:
//   An accepted operation moves with its RAM read data into the modify stage,
//   and its event enters the output register when it leaves that stage.
//   One operation per cycle is sustained unless an event stalls there: RAM
//   read at accept, modify and write-back as the stage completes, with a
//   one-entry write-forward register for a read of the entry just written.
// Reset:
//   After arst_n releases, a clearing pass writes every entry to zero,
//   SESSIONS (1024) entries in all, with in_stall held high the whole time.
// Stall:
//   A finished event waits in the output register. A further operation is
//   taken while that event waits; only an operation that itself produces an
//   event stalls in the modify stage, and in_stall rises behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_retransmit_timer_table_core
	import rtt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input channel
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [1:0]          operation,
	input  wire logic [SID_W-1:0]    session_id,
	input  wire logic [TYPE_W-1:0]   event_type,
	input  wire logic                stop,
	input  wire logic                event_queue_full,
	// output channel
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [1:0]          result_kind,
	output      logic [SID_W-1:0]    out_session,
	output      logic [TYPE_W-1:0]   out_type,
	output      logic [RETRY_W-1:0]  retry_count,
	// config channel
	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic [CFG_IX_W-1:0] cfg_index,
	input  wire logic [TIME_W-1:0]   cfg_data
);

	// ---- configuration ----
	cfg_t cfg;

	assign cfg_ready = 1'b1;

	rtt_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// ---- control state ----
	logic             clearing_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [IDX_W-1:0] scan_q;

	// modify stage: RAM data for this item is on rd_data
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [IDX_W-1:0]  addr_s1;
	logic [TYPE_W-1:0] etype_s1;
	logic              stop_s1;
	logic              full_s1;

	// last write-back, forwarded to a read that raced it
	logic              fwd_valid_q;
	logic [IDX_W-1:0]  fwd_addr_q;
	entry_t            fwd_data_q;

	// event output register
	logic               out_valid_q;
	kind_t              kind_q;
	logic [SID_W-1:0]   session_q;
	logic [TYPE_W-1:0]  type_q;
	logic [RETRY_W-1:0] retry_q;

	logic              in_xfer;
	logic              s1_go;
	logic [IDX_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	entry_t            cur;
	upd_t              upd;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;

	// ---- handshake ----
	// s1 completes unless it carries an event and the output register is stuck
	assign s1_go    = valid_s1 & (~upd.res_valid | ~out_valid_q | ~out_stall);
	assign in_stall = clearing_q | (valid_s1 & ~s1_go);
	assign in_xfer  = in_valid & ~in_stall;

	// tick reads the scan entry; set/clear read the addressed session
	assign rd_addr = (op_t'(operation) == OP_TICK) ? scan_q : IDX_W'(session_id);

	// ---- table RAM ----
	assign ram_we    = clearing_q | (s1_go & upd.wr);
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : upd.nxt;

	rtt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SESSIONS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_xfer),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// read-during-write returns old data: take the forwarded entry on a match
	assign cur = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : entry_t'(rd_data);

	rtt_update u_update (
		.cur        (cur),
		.op         (op_s1),
		.event_type (etype_s1),
		.stop       (stop_s1),
		.full       (full_s1),
		.cfg        (cfg),
		.upd        (upd)
	);

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			scan_q      <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// clearing pass, one entry per cycle
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
				if (clr_addr_q == IDX_W'(SESSIONS - 1)) begin
					clearing_q <= 1'b0;
				end
			end

			// scan pointer wraps at the table depth
			if (in_xfer && op_t'(operation) == OP_TICK) begin
				scan_q <= (scan_q == IDX_W'(SESSIONS - 1)) ? '0 : scan_q + IDX_W'(1);
			end

			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			if (s1_go && upd.wr) begin
				fwd_valid_q <= 1'b1;
			end

			if (s1_go && upd.res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1    <= operation;
			addr_s1  <= rd_addr;
			etype_s1 <= event_type;
			stop_s1  <= stop;
			full_s1  <= event_queue_full;
		end
		if (s1_go && upd.wr) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= upd.nxt;
		end
		if (s1_go && upd.res_valid) begin
			kind_q    <= upd.kind;
			session_q <= SID_W'(addr_s1);
			type_q    <= cur.etype;
			retry_q   <= upd.retry;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign out_session = session_q;
	assign out_type    = type_q;
	assign retry_count = retry_q;

endmodule : tcp_retransmit_timer_table_core

`default_nettype wire

// File: rtl/rtt_checker.sv
// ---------------------------------------------------------------------------
// rtt_checker: port-level checks of the timer table
// Watches handshakes, reset behavior and event encoding over time.
// ---------------------------------------------------------------------------
`default_nettype none

module rtt_checker
	import rtt_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic [1:0]          operation,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [1:0]          result_kind,
	input wire logic [SID_W-1:0]    out_session,
	input wire logic [TYPE_W-1:0]   out_type,
	input wire logic [RETRY_W-1:0]  retry_count
);

	// a stalled event stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) &&
			$stable(out_session) && $stable(out_type) && $stable(retry_count))
		else $error("stalled event changed");

	// the clearing pass blocks input right out of reset
	a_reset_stall: assert property (@(posedge clk)
		!arst_n |=> in_stall)
		else $error("input open during table clear");

	// retransmits carry 1..4 retries, aborts carry zero
	a_retry_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_kind == KIND_RETX) ?
			(retry_count != '0 && retry_count <= MAX_RETRIES) : (retry_count == '0))
		else $error("retry count does not match event kind");

	// a fresh event traces back to an accepted tick transfer
	a_event_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && operation == OP_TICK, 2))
		else $error("event without a tick");

endmodule : rtt_checker

bind tcp_retransmit_timer_table_core rtt_checker u_rtt_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for tcp_retransmit_timer_table_core
// Drives set / clear / tick operations with random gaps and output stalls.
// A timer table model in the testbench predicts each expiry event, and
// every event transfer is checked field by field in order.
// ---------------------------------------------------------------------------

module tb_top;
	import rtt_pkg::*;

	// Operation code 3 has no meaning; the block must ignore it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int HOT_COUNT     = 24;
	localparam int SETTLE_CYCLES = 8;
	// Operations sent per random phase.
	localparam int PHASE_ITEMS   = 180;
	// Cycles with no transfer on any channel before the run is declared hung.
	// Covers the post-reset clearing pass plus worst-case gaps and stalls.
	localparam int STUCK_LIMIT   = 4000;

	typedef struct {
		kind_t               kind;
		logic [SID_W-1:0]    session;
		logic [TYPE_W-1:0]   etype;
		logic [RETRY_W-1:0]  retry;
	} expiry_t;

	// Timer table model: mirrors the table, scan pointer and registers,
	// and queues the expiry events that accepted ticks must produce.
	class timer_table_model;
		logic [TIME_W-1:0]  timeout_at [5];
		logic [TYPE_W-1:0]  syn_code;
		logic [TIME_W-1:0]  time_left [SESSIONS];
		logic [RETRY_W-1:0] retries [SESSIONS];
		logic [TYPE_W-1:0]  etype [SESSIONS];
		bit                 armed [SESSIONS];
		int unsigned        scan_ptr;
		expiry_t            expiries_due [$];
		int                 mismatches;

		function new();
			timeout_at = '{32'd1000, 32'd5000, 32'd10000, 32'd15000, 32'd30000};
			syn_code = 4'd4;
			foreach (time_left[i]) begin
				time_left[i] = '0;
				retries[i] = '0;
				etype[i] = '0;
				armed[i] = 1'b0;
			end
			scan_ptr = 0;
			mismatches = 0;
		endfunction

		function void write_reg(reg_ix_t ix, logic [TIME_W-1:0] val);
			if (ix == REG_SYN_TYPE_CODE)
				syn_code = val[TYPE_W-1:0];
			else if (ix <= REG_TIMEOUT_LAST)
				timeout_at[ix] = val;
		endfunction

		function logic [TIME_W-1:0] backoff(logic [RETRY_W-1:0] level);
			return timeout_at[(level < MAX_RETRIES) ? level : MAX_RETRIES];
		endfunction

		// Called once per accepted operation transfer.
		function void apply_op(logic [1:0] op, logic [SID_W-1:0] sid,
				logic [TYPE_W-1:0] et, logic stp, logic full);
			int unsigned id;
			expiry_t ev;
			id = sid % SESSIONS;
			case (op)
				OP_SET: begin
					etype[id] = et;
					if (!armed[id])
						time_left[id] = backoff(retries[id]);
					armed[id] = 1'b1;
				end
				OP_CLEAR: begin
					if (stp) begin
						time_left[id] = '0;
						armed[id] = 1'b0;
					end else begin
						time_left[id] = timeout_at[0];
					end
					retries[id] = '0;
				end
				OP_TICK: begin
					id = scan_ptr;
					scan_ptr = (scan_ptr + 1) % SESSIONS;
					if (!armed[id]) begin
						// idle entry: only the pointer moves
					end else if (time_left[id] != 0) begin
						time_left[id]--;
					end else if (!full) begin
						armed[id] = 1'b0;
						ev.session = SID_W'(id);
						ev.etype = etype[id];
						if (retries[id] < MAX_RETRIES) begin
							retries[id]++;
							ev.kind = KIND_RETX;
							ev.retry = retries[id];
						end else begin
							retries[id] = '0;
							ev.kind = (etype[id] == syn_code) ? KIND_ABORT_OPEN
								: KIND_ABORT_TIMEOUT;
							ev.retry = '0;
						end
						expiries_due.push_back(ev);
					end
					// a full queue leaves the entry armed at zero for the next pass
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void match_expiry(logic [1:0] kind, logic [SID_W-1:0] sid,
				logic [TYPE_W-1:0] ty, logic [RETRY_W-1:0] retry);
			expiry_t want;
			if (expiries_due.size() == 0) begin
				$error("event for session %0d arrived with no expiry due", sid);
				mismatches++;
				return;
			end
			want = expiries_due.pop_front();
			compare_field("result_kind", 32'(want.kind), 32'(kind));
			compare_field("out_session", 32'(want.session), 32'(sid));
			compare_field("out_type", 32'(want.etype), 32'(ty));
			compare_field("retry_count", 32'(want.retry), 32'(retry));
		endfunction

		function void report_leftovers();
			foreach (expiries_due[i]) begin
				$error("expiry of session %0d never arrived", expiries_due[i].session);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          operation;
	logic [SID_W-1:0]    session_id;
	logic [TYPE_W-1:0]   event_type;
	logic                stop;
	logic                event_queue_full;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          result_kind;
	logic [SID_W-1:0]    out_session;
	logic [TYPE_W-1:0]   out_type;
	logic [RETRY_W-1:0]  retry_count;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [TIME_W-1:0]   cfg_data;

	timer_table_model    timers;
	logic [SID_W-1:0]    hot_sessions [HOT_COUNT];
	int                  stuck_cycles;
	// Pacing state per side: a span of items that is either calm (no
	// waiting at all) or jittery (a random wait drawn before each item).
	int                  in_span;
	bit                  in_calm;
	int                  out_span;
	bit                  out_calm;

	tcp_retransmit_timer_table_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.session_id       (session_id),
		.event_type       (event_type),
		.stop             (stop),
		.event_queue_full (event_queue_full),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.out_session      (out_session),
		.out_type         (out_type),
		.retry_count      (retry_count),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Wait cycles before the next transfer on one side.
	function automatic int draw_wait(ref int span, ref bit calm);
		if (span == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			span = $urandom_range(20, 200);
		end
		span--;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	// Target session for set / clear. Half of the set picks are hot sessions,
	// re-armed often so that their retries climb to the abort; most others
	// land just ahead of the scan pointer so ticks reach them, the rest anywhere.
	function automatic logic [SID_W-1:0] pick_target(input bit use_hot);
		int r;
		r = $urandom_range(0, 99);
		if (use_hot && r < 50)
			return hot_sessions[$urandom_range(0, HOT_COUNT - 1)];
		if (r < 85)
			return SID_W'((timers.scan_ptr + $urandom_range(0, 40)) % SESSIONS);
		return SID_W'($urandom_range(0, SESSIONS - 1));
	endfunction

	// One operation transfer. Entered right after a rising edge; the
	// payload holds until in_stall is low at a rising edge.
	task automatic send_op(input logic [1:0] op, input logic [SID_W-1:0] sid,
			input logic [TYPE_W-1:0] et, input logic stp, input logic full);
		int gap;
		gap = draw_wait(in_span, in_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		session_id <= sid;
		event_type <= et;
		stop <= stp;
		event_queue_full <= full;
		do @(posedge clk); while (in_stall);
		timers.apply_op(op, sid, et, stp, full);
	endtask

	// Drop valid and wait until every predicted event has been taken;
	// a trailing tick with no event may still be in flight, hence the pause.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (timers.expiries_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_ix_t ix, input logic [TIME_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		timers.write_reg(ix, val);
	endtask

	task automatic program_regs(input logic [TIME_W-1:0] t_first, t_second,
			t_third, t_fourth, t_last, input logic [TYPE_W-1:0] syn);
		write_reg(REG_TIMEOUT_FIRST, t_first);
		write_reg(REG_TIMEOUT_SECOND, t_second);
		write_reg(REG_TIMEOUT_THIRD, t_third);
		write_reg(REG_TIMEOUT_FOURTH, t_fourth);
		write_reg(REG_TIMEOUT_LAST, t_last);
		write_reg(REG_SYN_TYPE_CODE, TIME_W'(syn));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A short burst of random traffic; most clears and over a third of the sets
	// land just ahead of the scan pointer so that ticks reach them within the phase.
	task automatic run_phase();
		int sent;
		int r;
		logic [1:0]         op;
		logic [SID_W-1:0]   sid;
		logic [TYPE_W-1:0]  et;
		logic               stp;
		logic               full;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			sid = SID_W'($urandom);
			et = TYPE_W'($urandom);
			stp = 1'($urandom);
			full = 1'($urandom);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				op = OP_TICK;
				full = ($urandom_range(0, 4) == 0);
			end else if (r < 86) begin
				op = OP_SET;
				sid = pick_target(1'b1);
				// bias toward the SYN code so both abort kinds show up
				if ($urandom_range(0, 2) == 0)
					et = timers.syn_code;
			end else if (r < 97) begin
				op = OP_CLEAR;
				sid = pick_target(1'b0);
			end else begin
				op = OP_UNUSED;
			end
			send_op(op, sid, et, stp, full);
			sent++;
		end
	endtask

	// Stall watchdog: any transfer on any channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin : watchdog
		do @(posedge clk); while (stuck_cycles < STUCK_LIMIT);
		$display("tb_top: done, errors");
		$finish;
	end

	// Event receiver: checks each event transfer, then may hold stall high
	// for a random wait before the next one can go through.
	initial begin : receiver
		int hold;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				timers.match_expiry(result_kind, out_session, out_type, retry_count);
				hold = draw_wait(out_span, out_calm);
				if (hold > 0) begin
					@(negedge clk);
					out_stall <= 1'b1;
					repeat (hold) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		logic [SID_W-1:0] sid;
		timers = new();
		in_span = 0;
		in_calm = 1'b0;
		out_span = 0;
		out_calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_TICK;
		session_id = '0;
		event_type = '0;
		stop = 1'b0;
		event_queue_full = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TIMEOUT_FIRST;
		cfg_data = '0;
		hot_sessions[0] = '0;
		hot_sessions[1] = '1;
		for (int i = 2; i < HOT_COUNT; i++)
			hot_sessions[i] = SID_W'($urandom);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: arming loads the long default timeouts, so
		// nothing expires here; field extremes and the unused code.
		send_op(OP_SET, '1, '1, 1'b0, 1'b0);
		send_op(OP_SET, '0, '0, 1'b1, 1'b1);
		send_op(OP_TICK, 10'h155, 4'hA, 1'b1, 1'b1);
		send_op(OP_UNUSED, 10'h2AA, 4'h5, 1'b1, 1'b1);
		send_op(OP_CLEAR, '0, '0, 1'b1, 1'b0);
		send_op(OP_CLEAR, '1, '0, 1'b0, 1'b0);
		settle();

		// Zero timeouts: an armed entry expires the first time the scan
		// pointer reaches it.
		program_regs('0, '0, '0, '0, '0, 4'd4);
		sid = SID_W'(timers.scan_ptr);
		send_op(OP_SET, sid, 4'd4, 1'b0, 1'b0);
		send_op(OP_TICK, '0, '0, 1'b0, 1'b0);
		// expiry held off by a full event queue
		send_op(OP_SET, sid + 10'd1, 4'd3, 1'b0, 1'b0);
		send_op(OP_TICK, '0, '0, 1'b0, 1'b1);
		// set on an armed entry updates the type but does not reload time
		send_op(OP_SET, sid + 10'd2, 4'd1, 1'b0, 1'b0);
		send_op(OP_SET, sid + 10'd2, 4'd9, 1'b0, 1'b0);
		send_op(OP_TICK, '0, '0, 1'b0, 1'b0);
		// restart on an idle entry leaves it idle; the tick finds nothing
		send_op(OP_CLEAR, sid + 10'd3, 4'd0, 1'b0, 1'b0);
		send_op(OP_TICK, '0, '0, 1'b0, 1'b0);
		// stop disarms
		send_op(OP_SET, sid + 10'd4, 4'd2, 1'b0, 1'b0);
		send_op(OP_CLEAR, sid + 10'd4, 4'd0, 1'b1, 1'b0);
		send_op(OP_TICK, '0, '0, 1'b0, 1'b0);
		// restart on an armed entry keeps it armed at the first timeout
		send_op(OP_SET, sid + 10'd5, 4'd7, 1'b0, 1'b0);
		send_op(OP_CLEAR, sid + 10'd5, 4'd0, 1'b0, 1'b0);
		send_op(OP_TICK, '0, '0, 1'b0, 1'b0);

		// Random phases, one register setting each. Zero and one timeouts
		// let entries expire within a phase; the extreme ones park them.
		run_phase();
		settle();
		program_regs(32'd0, 32'd1, 32'd0, 32'd2, 32'd0, 4'd0);
		run_phase();
		settle();
		program_regs('0, '0, '0, '0, '0, TYPE_W'($urandom));
		run_phase();
		settle();
		program_regs('1, '0, '0, '0, '0, 4'hF);
		run_phase();
		settle();
		program_regs('0, '0, '0, '0, '0, 4'hF);
		run_phase();
		settle();
		program_regs('0, '0, '0, '0, '1, TYPE_W'($urandom));
		run_phase();
		settle();
		program_regs(TIME_W'($urandom_range(0, 1)), TIME_W'($urandom_range(0, 1)),
			TIME_W'($urandom_range(0, 1)), TIME_W'($urandom_range(0, 1)),
			TIME_W'($urandom_range(0, 1)), TYPE_W'($urandom));
		run_phase();
		settle();

		timers.report_leftovers();
		if (timers.mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/rtt_pkg.sv
rtl/rtt_ram.sv
rtl/rtt_regs.sv
rtl/rtt_update.sv
rtl/tcp_retransmit_timer_table_core.sv
rtl/rtt_checker.sv
tb/sv/tb_top.sv
